// File: hw/rtl/pipeline_hazard_control_macros.svh
// ----------------------------------------------------------------------------
// pipeline_hazard_control assertion macros
// Clocked assertion shorthands used by the checker file phc_checker.
// ----------------------------------------------------------------------------
`ifndef PIPELINE_HAZARD_CONTROL_MACROS_SVH
`define PIPELINE_HAZARD_CONTROL_MACROS_SVH

// same-cycle implication, disabled in reset
`define PHC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define PHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/phc_pkg.sv
// ----------------------------------------------------------------------------
// phc_pkg
// Types and constants of the pipeline hazard and forwarding control.
// ----------------------------------------------------------------------------
package phc_pkg;

   // architectural register count; indexes at or above it are not registers
   localparam int REG_COUNT = 32;

   typedef enum logic [1:0] {
      KIND_ORDINARY = 2'd0,
      KIND_BRANCH   = 2'd1,
      KIND_JUMP     = 2'd2,
      KIND_RETURN   = 2'd3
   } kind_type;

   // EX operand source selects
   localparam logic [1:0] FWD_LATCH = 2'd0;
   localparam logic [1:0] FWD_EXMEM = 2'd1;
   localparam logic [1:0] FWD_MEMWB = 2'd2;

   // CSR word index of forward_enable
   localparam logic CSR_IDX_FWD_EN = 1'b0;

   typedef struct packed {
      logic       valid;
      logic [4:0] src_a;
      logic       a_used;
      logic [4:0] src_b;
      logic       b_used;
      logic [4:0] dest;
      logic       reg_write;
      logic       mem_read;
      kind_type   kind;
   } stage_ctl_type;

   typedef struct packed {
      logic       fetch_valid;
      logic [4:0] new_src_a;
      logic       new_src_a_used;
      logic [4:0] new_src_b;
      logic       new_src_b_used;
      logic [4:0] new_dest;
      logic       new_reg_write;
      logic       new_mem_read;
      kind_type   new_kind;
      logic       ex_branch_taken;
   } req_item_type;

   typedef struct packed {
      logic       fetch_taken;
      logic       stall_res;
      logic       flush;
      logic       stop_fetch;
      logic [1:0] fwd_a;
      logic [1:0] fwd_b;
      logic       retire;
      logic       wb_enable;
      logic [4:0] wb_reg;
      logic       drained;
   } rsp_item_type;

endpackage

// File: hw/rtl/phc_csr.sv
// ----------------------------------------------------------------------------
// phc_csr
// APB register slave holding the forwarding enable.
// ----------------------------------------------------------------------------
module phc_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic        forward_enable
);

   logic fwd_en_ff;
   logic fwd_en_in;
   logic wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == phc_pkg::CSR_IDX_FWD_EN);

   always_comb begin
      fwd_en_in = fwd_en_ff;
      if (wr_hit) begin
         fwd_en_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_en_ff <= 1'b1;
      end else begin
         fwd_en_ff <= fwd_en_in;
      end
   end

   // low bits of the address are ignored; any word past the list reads zero
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == phc_pkg::CSR_IDX_FWD_EN) begin
         csr_prdata = {31'd0, fwd_en_ff};
      end
   end

   assign forward_enable = fwd_en_ff;

endmodule

// File: hw/rtl/phc_core.sv
// ----------------------------------------------------------------------------
// phc_core
// Pipeline latch control state and the per-tick hazard, flush and
// forwarding decision.
// ----------------------------------------------------------------------------
module phc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   forward_enable,
   input  phc_pkg::req_item_type  item,
   output phc_pkg::rsp_item_type  result
);

   phc_pkg::stage_ctl_type decode_ff, decode_in;
   phc_pkg::stage_ctl_type execute_ff, execute_in;
   phc_pkg::stage_ctl_type memory_ff, memory_in;
   phc_pkg::stage_ctl_type writeback_ff, writeback_in;
   phc_pkg::stage_ctl_type offered;
   logic                   halted_ff, halted_in;
   logic                   raw_stall;
   logic                   flush;
   logic                   stop;
   logic                   stall;
   logic                   take;
   logic                   wb;

   function automatic logic is_real_reg(logic [4:0] r);
      return (r != 5'd0) && (int'(r) < phc_pkg::REG_COUNT);
   endfunction

   function automatic logic produces(phc_pkg::stage_ctl_type p);
      return p.valid && p.reg_write && is_real_reg(p.dest);
   endfunction

   function automatic logic conflicts(phc_pkg::stage_ctl_type p,
                                      phc_pkg::stage_ctl_type c);
      return produces(p) &&
             ((c.a_used && is_real_reg(c.src_a) && (c.src_a == p.dest)) ||
              (c.b_used && is_real_reg(c.src_b) && (c.src_b == p.dest)));
   endfunction

   // a load in EX/MEM has no data yet, so it only forwards from MEM/WB
   function automatic logic [1:0] select_source(logic fwd_en, logic used,
                                                logic [4:0] r,
                                                phc_pkg::stage_ctl_type mem,
                                                phc_pkg::stage_ctl_type wbl);
      logic [1:0] sel;
      sel = phc_pkg::FWD_LATCH;
      if (fwd_en && used && is_real_reg(r)) begin
         if (produces(mem) && !mem.mem_read && (mem.dest == r)) begin
            sel = phc_pkg::FWD_EXMEM;
         end else if (produces(wbl) && (wbl.dest == r)) begin
            sel = phc_pkg::FWD_MEMWB;
         end
      end
      return sel;
   endfunction

   always_comb begin
      offered.valid     = 1'b1;
      offered.src_a     = item.new_src_a;
      offered.a_used    = item.new_src_a_used;
      offered.src_b     = item.new_src_b;
      offered.b_used    = item.new_src_b_used;
      offered.dest      = item.new_dest;
      offered.reg_write = item.new_reg_write;
      offered.mem_read  = item.new_mem_read;
      offered.kind      = item.new_kind;
   end

   always_comb begin
      raw_stall = 1'b0;
      if (decode_ff.valid) begin
         if (forward_enable) begin
            raw_stall = execute_ff.valid && execute_ff.mem_read &&
                        conflicts(execute_ff, decode_ff);
         end else begin
            raw_stall = conflicts(execute_ff, decode_ff) ||
                        conflicts(memory_ff, decode_ff);
         end
      end
   end

   always_comb begin
      flush = 1'b0;
      stop  = 1'b0;
      if (execute_ff.valid) begin
         unique case (execute_ff.kind)
            phc_pkg::KIND_RETURN: begin
               flush = 1'b1;
               stop  = 1'b1;
            end
            phc_pkg::KIND_JUMP: begin
               flush = 1'b1;
            end
            phc_pkg::KIND_BRANCH: begin
               flush = item.ex_branch_taken;
            end
            phc_pkg::KIND_ORDINARY: begin
               flush = 1'b0;
            end
         endcase
      end
   end

   // flush wins over a stall
   assign stall = raw_stall && !flush;
   assign take  = item.fetch_valid && !halted_ff && !stall;
   assign wb    = writeback_ff.valid && writeback_ff.reg_write &&
                  (int'(writeback_ff.dest) < phc_pkg::REG_COUNT);

   always_comb begin
      result.fetch_taken = take;
      result.stall_res   = stall;
      result.flush       = flush;
      result.stop_fetch  = stop;
      result.fwd_a       = phc_pkg::FWD_LATCH;
      result.fwd_b       = phc_pkg::FWD_LATCH;
      if (execute_ff.valid) begin
         result.fwd_a = select_source(forward_enable, execute_ff.a_used,
                                      execute_ff.src_a, memory_ff, writeback_ff);
         result.fwd_b = select_source(forward_enable, execute_ff.b_used,
                                      execute_ff.src_b, memory_ff, writeback_ff);
      end
      result.retire    = execute_ff.valid;
      result.wb_enable = wb;
      result.wb_reg    = wb ? writeback_ff.dest : 5'd0;
      result.drained   = halted_ff && !decode_ff.valid && !execute_ff.valid &&
                         !memory_ff.valid && !writeback_ff.valid;
   end

   always_comb begin
      writeback_in = writeback_ff;
      memory_in    = memory_ff;
      execute_in   = execute_ff;
      decode_in    = decode_ff;
      halted_in    = halted_ff;
      if (advance) begin
         writeback_in = memory_ff;
         memory_in    = execute_ff;
         execute_in   = (flush || stall) ? phc_pkg::stage_ctl_type'('0) : decode_ff;
         if (flush) begin
            decode_in = '0;
         end else if (!stall) begin
            decode_in = take ? offered : phc_pkg::stage_ctl_type'('0);
         end
         halted_in = halted_ff || stop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_ff    <= '0;
         execute_ff   <= '0;
         memory_ff    <= '0;
         writeback_ff <= '0;
         halted_ff    <= 1'b0;
      end else begin
         decode_ff    <= decode_in;
         execute_ff   <= execute_in;
         memory_ff    <= memory_in;
         writeback_ff <= writeback_in;
         halted_ff    <= halted_in;
      end
   end

endmodule

// File: hw/rtl/pipeline_hazard_control.sv
// ----------------------------------------------------------------------------
// pipeline_hazard_control
// Hazard, forwarding and flush control of a five-stage in-order pipeline:
// one request transfer per clock tick, one response transfer per tick.
// ----------------------------------------------------------------------------
//   channel   direction  role
//   req_*     in         tick: offered instruction control + EX branch outcome
//   rsp_*     out        tick decision: stall, flush, forwarding, write-back
//   csr_*     in/out     APB register port, forward_enable at word 0
//
// A tick is registered at the input, decided in one pass through phc_core
// and registered at the output: one tick per cycle unless the output stalls.
// The latch state advances in the cycle the tick moves into the output
// register. A stalled output holds its transfer while the input register
// still takes one more tick. Reset empties all latches and sets
// forward_enable.
// ----------------------------------------------------------------------------
module pipeline_hazard_control (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] fetch_valid, [5:1] new_src_a, [6] new_src_a_used, [11:7] new_src_b,
   // [12] new_src_b_used, [17:13] new_dest, [18] new_reg_write,
   // [19] new_mem_read, [21:20] new_kind, [22] ex_branch_taken, [23] zero
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] fetch_taken, [1] stall_res, [2] flush, [3] stop_fetch, [5:4] fwd_a,
   // [7:6] fwd_b, [8] retire, [9] wb_enable, [14:10] wb_reg, [15] drained
   output logic [15:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   phc_pkg::req_item_type in_item_ff, in_item_in, req_item;
   phc_pkg::rsp_item_type rsp_item_ff, rsp_item_in, core_result;
   logic                  in_valid_ff, in_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  advance;
   logic                  req_xfer;
   logic                  forward_enable;

   always_comb begin
      req_item.fetch_valid     = req_tdata[0];
      req_item.new_src_a       = req_tdata[5:1];
      req_item.new_src_a_used  = req_tdata[6];
      req_item.new_src_b       = req_tdata[11:7];
      req_item.new_src_b_used  = req_tdata[12];
      req_item.new_dest        = req_tdata[17:13];
      req_item.new_reg_write   = req_tdata[18];
      req_item.new_mem_read    = req_tdata[19];
      req_item.new_kind        = phc_pkg::kind_type'(req_tdata[21:20]);
      req_item.ex_branch_taken = req_tdata[22];
   end

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = core_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   phc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .forward_enable (forward_enable)
   );

   phc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .forward_enable (forward_enable),
      .item           (in_item_ff),
      .result         (core_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_item_ff.drained, rsp_item_ff.wb_reg, rsp_item_ff.wb_enable,
                        rsp_item_ff.retire, rsp_item_ff.fwd_b, rsp_item_ff.fwd_a,
                        rsp_item_ff.stop_fetch, rsp_item_ff.flush,
                        rsp_item_ff.stall_res, rsp_item_ff.fetch_taken};

endmodule

// File: hw/rtl/phc_checker.sv
// ----------------------------------------------------------------------------
// phc_checker
// Port-level checks on the response stream of the hazard control.
// ----------------------------------------------------------------------------
`include "pipeline_hazard_control_macros.svh"

module phc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic       fetch_taken;
   logic       stall_res;
   logic       flush;
   logic       stop_fetch;
   logic [1:0] fwd_a;
   logic [1:0] fwd_b;
   logic       wb_enable;
   logic [4:0] wb_reg;

   assign fetch_taken = rsp_tdata[0];
   assign stall_res   = rsp_tdata[1];
   assign flush       = rsp_tdata[2];
   assign stop_fetch  = rsp_tdata[3];
   assign fwd_a       = rsp_tdata[5:4];
   assign fwd_b       = rsp_tdata[7:6];
   assign wb_enable   = rsp_tdata[9];
   assign wb_reg      = rsp_tdata[14:10];

   // flush overrides stall; a stalled tick never takes the fetched instruction
   `PHC_ASSERT_NOW(a_stall_excl, clock, reset, rsp_tvalid && stall_res, !flush && !fetch_taken, "stall with flush or fetch")
   // a return always squashes the younger stages
   `PHC_ASSERT_NOW(a_stop_flush, clock, reset, rsp_tvalid && stop_fetch, flush, "stop_fetch without flush")
   `PHC_ASSERT_NOW(a_wb_reg_zero, clock, reset, rsp_tvalid && !wb_enable, wb_reg == 5'd0, "wb_reg set while wb disabled")
   `PHC_ASSERT_NOW(a_fwd_code, clock, reset, rsp_tvalid, (fwd_a != 2'd3) && (fwd_b != 2'd3), "undefined forwarding select")
   `PHC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

endmodule

bind pipeline_hazard_control phc_checker u_phc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
